// ----- rtl/sxt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_pkg
// Shared types, sizes and codes for the S-expression tokenizer.
// ----------------------------------------------------------------------------
package sxt_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int LENGTH_BITS = 16;
    localparam int DEPTH_BITS  = $clog2(MAX_DEPTH + 1);
    localparam int MAX_RESULTS = 3;

    // event codes
    localparam logic [2:0] EV_OPEN  = 3'd0;
    localparam logic [2:0] EV_CLOSE = 3'd1;
    localparam logic [2:0] EV_ID    = 3'd2;
    localparam logic [2:0] EV_STR   = 3'd3;
    localparam logic [2:0] EV_NUM   = 3'd4;
    localparam logic [2:0] EV_ERR   = 3'd5;
    localparam logic [2:0] EV_OK    = 3'd6;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_BAD_ID_CHAR = 4'd1;
    localparam logic [3:0] ERR_END_IN_ID   = 4'd2;
    localparam logic [3:0] ERR_END_IN_STR  = 4'd3;
    localparam logic [3:0] ERR_AFTER_STR   = 4'd4;
    localparam logic [3:0] ERR_SECOND_DOT  = 4'd5;
    localparam logic [3:0] ERR_BAD_NUM     = 4'd6;
    localparam logic [3:0] ERR_END_IN_NUM  = 4'd7;
    localparam logic [3:0] ERR_BAD_IN_LIST = 4'd8;
    localparam logic [3:0] ERR_END_IN_LIST = 4'd9;
    localparam logic [3:0] ERR_BAD_TOP     = 4'd10;
    localparam logic [3:0] ERR_DEPTH       = 4'd11;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  error_code;
        logic [6:0]  nest_depth;
        logic [15:0] token_length;
        logic        last_of_run;
    } out_t;

    // all results caused by one source byte
    typedef struct packed {
        logic [1:0]                   count;
        out_t [MAX_RESULTS-1:0]       res;
    } bundle_t;

endpackage
`default_nettype wire

// ----- rtl/sxt_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_in_reg
// Input register: holds one source request until the scan core takes it.
// ----------------------------------------------------------------------------
module sxt_in_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         src_valid,
    output logic              src_stall,
    input  wire sxt_pkg::in_t src_item,
    input  wire logic         take,
    output logic              held_valid,
    output sxt_pkg::in_t      held_item
);

    logic         valid_reg;
    sxt_pkg::in_t item_reg;

    assign src_stall  = valid_reg && !take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (src_valid && !src_stall)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            item_reg <= src_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sxt_scan_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_scan_core
// Scan state machine: classifies one byte, updates mode, depth, decimal flag
// and token length, and forms up to three results for that byte.
// ----------------------------------------------------------------------------
module sxt_scan_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire sxt_pkg::in_t item,
    input  wire logic         take,
    output sxt_pkg::bundle_t  bundle
);

    localparam logic [2:0] MODE_TOP   = 3'd0;
    localparam logic [2:0] MODE_LIST  = 3'd1;
    localparam logic [2:0] MODE_ID    = 3'd2;
    localparam logic [2:0] MODE_STR   = 3'd3;
    localparam logic [2:0] MODE_ESC   = 3'd4;
    localparam logic [2:0] MODE_AFTER = 3'd5;
    localparam logic [2:0] MODE_NUM   = 3'd6;
    localparam logic [2:0] MODE_DEAD  = 3'd7;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [sxt_pkg::DEPTH_BITS-1:0] DEPTH_LIMIT =
        sxt_pkg::DEPTH_BITS'(sxt_pkg::MAX_DEPTH);
    localparam logic [sxt_pkg::DEPTH_BITS-1:0]  DEPTH_ONE = sxt_pkg::DEPTH_BITS'(1);
    localparam logic [sxt_pkg::LENGTH_BITS-1:0] LEN_ONE   = sxt_pkg::LENGTH_BITS'(1);

    logic [2:0]                         mode_reg,  mode_next;
    logic [sxt_pkg::DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic                               dec_reg,   dec_next;
    logic [sxt_pkg::LENGTH_BITS-1:0]    len_reg,   len_next;

    logic [7:0]                  c;
    logic                        c_space, c_digit, c_alpha, c_punct;
    logic                        do_close;
    logic [1:0]                  n;
    sxt_pkg::out_t [sxt_pkg::MAX_RESULTS-1:0] res;

    function automatic sxt_pkg::out_t mk(input logic [2:0] ev, input logic [3:0] err,
                                         input logic [sxt_pkg::DEPTH_BITS-1:0] d,
                                         input logic [sxt_pkg::LENGTH_BITS-1:0] l);
        sxt_pkg::out_t r;
        r.event_res    = ev;
        r.error_code   = err;
        r.nest_depth   = 7'(d);
        r.token_length = 16'(l);
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    assign c       = item.source_byte;
    assign c_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign c_digit = (c >= 8'h30 && c <= 8'h39);
    assign c_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign c_punct = (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                     (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);

    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        dec_next   = dec_reg;
        len_next   = len_reg;
        do_close   = 1'b0;
        n          = 2'd0;
        res        = '0;

        unique case (mode_reg)
            MODE_TOP:
            begin
                if (c == CH_OPEN)
                begin
                    depth_next = sxt_pkg::DEPTH_BITS'(1);
                    mode_next  = MODE_LIST;
                    res[n]     = mk(sxt_pkg::EV_OPEN, sxt_pkg::ERR_NONE, depth_next, '0);
                    n          = n + 2'd1;
                end
                else if (!c_space)
                begin
                    res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_BAD_TOP, depth_next, '0);
                    n         = n + 2'd1;
                    mode_next = MODE_DEAD;
                end
            end
            MODE_LIST:
            begin
                if (c_space)
                begin
                    mode_next = MODE_LIST;
                end
                else if (c_digit)
                begin
                    mode_next = MODE_NUM;
                    len_next  = sxt_pkg::LENGTH_BITS'(1);
                    dec_next  = 1'b0;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                    len_next  = sxt_pkg::LENGTH_BITS'(1);
                end
                else if (c == CH_OPEN)
                begin
                    if (depth_reg >= DEPTH_LIMIT)
                    begin
                        res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_DEPTH, depth_next, '0);
                        n         = n + 2'd1;
                        mode_next = MODE_DEAD;
                    end
                    else
                    begin
                        depth_next = depth_reg + DEPTH_ONE;
                        res[n]     = mk(sxt_pkg::EV_OPEN, sxt_pkg::ERR_NONE, depth_next, '0);
                        n          = n + 2'd1;
                    end
                end
                else if (c == CH_CLOSE)
                begin
                    do_close = 1'b1;
                end
                else if (c_punct || c_alpha)
                begin
                    mode_next = MODE_ID;
                    len_next  = sxt_pkg::LENGTH_BITS'(1);
                end
                else
                begin
                    res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_BAD_IN_LIST, depth_next, '0);
                    n         = n + 2'd1;
                    mode_next = MODE_DEAD;
                end
            end
            MODE_ID:
            begin
                if (c_space || c == CH_CLOSE)
                begin
                    res[n]    = mk(sxt_pkg::EV_ID, sxt_pkg::ERR_NONE, depth_next, len_reg);
                    n         = n + 2'd1;
                    mode_next = MODE_LIST;
                    do_close  = (c == CH_CLOSE);
                end
                else if (!c_punct && !c_alpha && !c_digit)
                begin
                    res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_BAD_ID_CHAR, depth_next, '0);
                    n         = n + 2'd1;
                    mode_next = MODE_DEAD;
                end
                else if (len_reg != '1)
                begin
                    len_next = len_reg + LEN_ONE;
                end
            end
            MODE_STR, MODE_ESC:
            begin
                if (len_reg != '1)
                begin
                    len_next = len_reg + LEN_ONE;
                end
                if (mode_reg == MODE_ESC)
                begin
                    mode_next = MODE_STR;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = MODE_AFTER;
                end
                else if (c == CH_BSL)
                begin
                    mode_next = MODE_ESC;
                end
            end
            MODE_AFTER:
            begin
                if (c_space || c == CH_CLOSE)
                begin
                    res[n]    = mk(sxt_pkg::EV_STR, sxt_pkg::ERR_NONE, depth_next, len_reg);
                    n         = n + 2'd1;
                    mode_next = MODE_LIST;
                    do_close  = (c == CH_CLOSE);
                end
                else
                begin
                    res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_AFTER_STR, depth_next, '0);
                    n         = n + 2'd1;
                    mode_next = MODE_DEAD;
                end
            end
            MODE_NUM:
            begin
                if (c_space || c == CH_CLOSE)
                begin
                    res[n]    = mk(sxt_pkg::EV_NUM, sxt_pkg::ERR_NONE, depth_next, len_reg);
                    n         = n + 2'd1;
                    mode_next = MODE_LIST;
                    do_close  = (c == CH_CLOSE);
                end
                else if (c == CH_DOT && dec_reg)
                begin
                    res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_SECOND_DOT, depth_next, '0);
                    n         = n + 2'd1;
                    mode_next = MODE_DEAD;
                end
                else if (c != CH_DOT && !c_alpha && !c_digit)
                begin
                    res[n]    = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_BAD_NUM, depth_next, '0);
                    n         = n + 2'd1;
                    mode_next = MODE_DEAD;
                end
                else
                begin
                    dec_next = dec_reg || (c == CH_DOT);
                    if (len_reg != '1)
                    begin
                        len_next = len_reg + LEN_ONE;
                    end
                end
            end
            MODE_DEAD:
            begin
                mode_next = MODE_DEAD;
            end
            default:
            begin
                mode_next = MODE_DEAD;
            end
        endcase

        // close the current list after any token it ends
        if (do_close)
        begin
            if (depth_next != '0)
            begin
                depth_next = depth_next - DEPTH_ONE;
            end
            res[n]    = mk(sxt_pkg::EV_CLOSE, sxt_pkg::ERR_NONE, depth_next, '0);
            n         = n + 2'd1;
            mode_next = (depth_next == '0) ? MODE_TOP : MODE_LIST;
        end

        if (item.end_of_source)
        begin
            case (mode_next)
                MODE_TOP:
                begin
                    res[n] = mk(sxt_pkg::EV_OK, sxt_pkg::ERR_NONE, depth_next, '0);
                    n      = n + 2'd1;
                end
                MODE_LIST:
                begin
                    res[n] = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_LIST, depth_next, '0);
                    n      = n + 2'd1;
                end
                MODE_ID:
                begin
                    res[n] = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_ID, depth_next, '0);
                    n      = n + 2'd1;
                end
                MODE_STR, MODE_ESC, MODE_AFTER:
                begin
                    res[n] = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_STR, depth_next, '0);
                    n      = n + 2'd1;
                end
                MODE_NUM:
                begin
                    res[n] = mk(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_NUM, depth_next, '0);
                    n      = n + 2'd1;
                end
                default:
                begin
                    n = n;
                end
            endcase
            mode_next  = MODE_TOP;
            depth_next = '0;
            dec_next   = 1'b0;
            len_next   = '0;
        end

        if (n != 2'd0)
        begin
            res[n - 2'd1].last_of_run = 1'b1;
        end
    end

    assign bundle.count = n;
    assign bundle.res   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TOP;
            depth_reg <= '0;
            dec_reg   <= 1'b0;
            len_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            dec_reg   <= dec_next;
            len_reg   <= len_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sxt_result_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_result_buf
// Result register: holds the results of one byte and hands them out one
// result per cycle while res_stall is low.
// ----------------------------------------------------------------------------
module sxt_result_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sxt_pkg::bundle_t bundle,
    input  wire logic             load,
    output logic                  free,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output sxt_pkg::out_t         res_item
);

    logic [1:0]                                count_reg;
    logic [1:0]                                idx_reg;
    sxt_pkg::out_t [sxt_pkg::MAX_RESULTS-1:0]  res_reg;
    logic                                      taken;
    logic                                      last_taken;

    assign res_valid  = (count_reg != 2'd0);
    assign res_item   = res_reg[idx_reg];
    assign taken      = res_valid && !res_stall;
    assign last_taken = taken && (idx_reg == count_reg - 2'd1);
    assign free       = !res_valid || last_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else if (load && bundle.count != 2'd0)
        begin
            count_reg <= bundle.count;
            idx_reg   <= 2'd0;
        end
        else if (last_taken)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else if (taken)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && bundle.count != 2'd0)
        begin
            res_reg <= bundle.res;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/s_expression_tokenizer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s_expression_tokenizer_unit
// Byte-serial S-expression tokenizer: list open/close events, token ends with
// their lengths, errors and end-of-source status.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+---------------------------------
//  source  | src_valid, src_stall, src_item| byte + end flag (sxt_pkg::in_t)
//  result  | res_valid, res_stall, res_item| event record (sxt_pkg::out_t)
//
//  One byte per cycle while each byte gives at most one result and res_stall
//  is low; a byte that gives more results (up to 3) holds the pipe while the
//  single result port drains the result register.
//  First result of a byte passes the input register and then the result
//  register before it shows on res_item; a busy result register delays it.
//  rst_n clears mode, depth, length and all valid flags at once.
//  res_stall backs up through the result register into src_stall.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         src_valid,
    output logic              src_stall,
    input  wire sxt_pkg::in_t src_item,
    output logic              res_valid,
    input  wire logic         res_stall,
    output sxt_pkg::out_t     res_item
);

    logic             held_valid;
    sxt_pkg::in_t     held_item;
    logic             free;
    logic             take;
    sxt_pkg::bundle_t bundle;

    assign take = held_valid && free;

    sxt_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    sxt_scan_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (held_item),
        .take   (take),
        .bundle (bundle)
    );

    sxt_result_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .bundle    (bundle),
        .load      (take),
        .free      (free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
`default_nettype wire

// ----- rtl/sxt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sxt_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
module sxt_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire sxt_pkg::out_t res_item
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_item.event_res == sxt_pkg::EV_ERR) ==
                       (res_item.error_code != sxt_pkg::ERR_NONE)))
        else $error("error code does not match event");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.event_res == sxt_pkg::EV_OPEN ||
                      res_item.event_res == sxt_pkg::EV_CLOSE ||
                      res_item.event_res == sxt_pkg::EV_ERR ||
                      res_item.event_res == sxt_pkg::EV_OK)
        |-> res_item.token_length == 16'd0)
        else $error("length on non-token event");

    a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.event_res == sxt_pkg::EV_OK |->
        res_item.nest_depth == 7'd0 && res_item.last_of_run)
        else $error("source accepted with open lists or not last");

    a_open_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.event_res == sxt_pkg::EV_OPEN |->
        res_item.nest_depth != 7'd0)
        else $error("list open at depth zero");

endmodule

bind s_expression_tokenizer_unit sxt_checker u_sxt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);
`default_nettype wire

// ----- verif/s_expression_tokenizer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_expression_tokenizer_unit_tb
// Feeds source text to the tokenizer and checks every event record it emits.
// The text comes from a short scripted part, then random lists and atoms with
// occasional flaws and cut-off ends, then a nesting-limit pass. A behavioral
// tokenizer in this file predicts each request's events. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_unit_tb;

    localparam int RANDOM_ITEMS  = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam longint unsigned LEN_CAP = (64'd1 << sxt_pkg::LENGTH_BITS) - 1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ESC   = 8'h5C;

    typedef enum logic [2:0] {
        SCAN_TOP, SCAN_LIST, SCAN_ID, SCAN_STR, SCAN_ESC, SCAN_AFTER, SCAN_NUM, SCAN_DEAD
    } scan_t;

    // one request plus, for scripted rows, the event it must give
    typedef struct packed {
        sxt_pkg::in_t  item;
        logic          pinned;
        sxt_pkg::out_t want;
    } feed_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          src_valid = 1'b0;
    logic          src_stall;
    sxt_pkg::in_t  src_item  = '0;
    logic          res_valid;
    logic          res_stall = 1'b0;
    sxt_pkg::out_t res_item;

    s_expression_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #10 clk = ~clk;

    // tokenizer state as predicted
    scan_t           scan_now  = SCAN_TOP;
    int unsigned     depth_now = 0;
    bit              dot_now   = 1'b0;
    longint unsigned len_now   = 0;

    sxt_pkg::out_t step_res[$];
    sxt_pkg::out_t pending_events[$];
    feed_t         src_queue[$];
    feed_t         src_now = '0;
    logic [7:0]    run_text[$];

    logic src_took  = 1'b0;
    bit   no_idle   = 1'b0;
    bit   hold_go   = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int events_checked = 0;
    int errors_seen    = 0;
    int sources_ok     = 0;
    int deepest        = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_digit_ch(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit is_mark(logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic void post_event(logic [2:0] ev, logic [3:0] code, longint unsigned n);
        sxt_pkg::out_t r;
        if (step_res.size() >= sxt_pkg::MAX_RESULTS)
            return;
        r.event_res    = ev;
        r.error_code   = code;
        r.nest_depth   = depth_now[6:0];
        r.token_length = n[15:0];
        r.last_of_run  = 1'b0;
        step_res.push_back(r);
        if (depth_now > deepest)
            deepest = depth_now;
    endfunction

    function automatic void raise_error(logic [3:0] code);
        post_event(sxt_pkg::EV_ERR, code, 0);
        scan_now = SCAN_DEAD;
    endfunction

    function automatic void grow_len();
        if (len_now < LEN_CAP)
            len_now++;
    endfunction

    function automatic void close_level();
        if (depth_now > 0)
            depth_now--;
        post_event(sxt_pkg::EV_CLOSE, sxt_pkg::ERR_NONE, 0);
        scan_now = (depth_now == 0) ? SCAN_TOP : SCAN_LIST;
    endfunction

    // Predict the events of one source byte into step_res.
    function automatic void tokenize_byte(sxt_pkg::in_t item);
        logic [7:0]    c;
        sxt_pkg::out_t tail;
        c = item.source_byte;
        step_res.delete();
        case (scan_now)
            SCAN_TOP:
                if (c == CH_OPEN)
                begin
                    depth_now = 1;
                    scan_now  = SCAN_LIST;
                    post_event(sxt_pkg::EV_OPEN, sxt_pkg::ERR_NONE, 0);
                end
                else if (!is_blank(c))
                    raise_error(sxt_pkg::ERR_BAD_TOP);
            SCAN_LIST:
                if (!is_blank(c))
                begin
                    if (is_digit_ch(c))
                    begin
                        scan_now = SCAN_NUM;
                        len_now  = 1;
                        dot_now  = 1'b0;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        scan_now = SCAN_STR;
                        len_now  = 1;
                    end
                    else if (c == CH_OPEN)
                    begin
                        if (depth_now >= sxt_pkg::MAX_DEPTH)
                            raise_error(sxt_pkg::ERR_DEPTH);
                        else
                        begin
                            depth_now++;
                            post_event(sxt_pkg::EV_OPEN, sxt_pkg::ERR_NONE, 0);
                        end
                    end
                    else if (c == CH_CLOSE)
                        close_level();
                    else if (is_mark(c) || is_letter(c))
                    begin
                        scan_now = SCAN_ID;
                        len_now  = 1;
                    end
                    else
                        raise_error(sxt_pkg::ERR_BAD_IN_LIST);
                end
            SCAN_ID:
                if (is_blank(c))
                begin
                    post_event(sxt_pkg::EV_ID, sxt_pkg::ERR_NONE, len_now);
                    scan_now = SCAN_LIST;
                end
                else if (c == CH_CLOSE)
                begin
                    post_event(sxt_pkg::EV_ID, sxt_pkg::ERR_NONE, len_now);
                    close_level();
                end
                else if (!is_mark(c) && !is_letter(c) && !is_digit_ch(c))
                    raise_error(sxt_pkg::ERR_BAD_ID_CHAR);
                else
                    grow_len();
            SCAN_STR:
            begin
                grow_len();
                if (c == CH_QUOTE)
                    scan_now = SCAN_AFTER;
                else if (c == CH_ESC)
                    scan_now = SCAN_ESC;
            end
            SCAN_ESC:
            begin
                grow_len();
                scan_now = SCAN_STR;
            end
            SCAN_AFTER:
                if (c == CH_CLOSE)
                begin
                    post_event(sxt_pkg::EV_STR, sxt_pkg::ERR_NONE, len_now);
                    close_level();
                end
                else if (is_blank(c))
                begin
                    post_event(sxt_pkg::EV_STR, sxt_pkg::ERR_NONE, len_now);
                    scan_now = SCAN_LIST;
                end
                else
                    raise_error(sxt_pkg::ERR_AFTER_STR);
            SCAN_NUM:
                if (is_blank(c))
                begin
                    post_event(sxt_pkg::EV_NUM, sxt_pkg::ERR_NONE, len_now);
                    scan_now = SCAN_LIST;
                end
                else if (c == CH_CLOSE)
                begin
                    post_event(sxt_pkg::EV_NUM, sxt_pkg::ERR_NONE, len_now);
                    close_level();
                end
                else if (c == CH_DOT)
                begin
                    if (dot_now)
                        raise_error(sxt_pkg::ERR_SECOND_DOT);
                    else
                    begin
                        dot_now = 1'b1;
                        grow_len();
                    end
                end
                else if (!is_letter(c) && !is_digit_ch(c))
                    raise_error(sxt_pkg::ERR_BAD_NUM);
                else
                    grow_len();
            default: ;
        endcase

        if (item.end_of_source)
        begin
            case (scan_now)
                SCAN_TOP:
                    post_event(sxt_pkg::EV_OK, sxt_pkg::ERR_NONE, 0);
                SCAN_LIST:
                    post_event(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_LIST, 0);
                SCAN_ID:
                    post_event(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_ID, 0);
                SCAN_STR, SCAN_ESC, SCAN_AFTER:
                    post_event(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_STR, 0);
                SCAN_NUM:
                    post_event(sxt_pkg::EV_ERR, sxt_pkg::ERR_END_IN_NUM, 0);
                default: ;
            endcase
            scan_now  = SCAN_TOP;
            depth_now = 0;
            dot_now   = 1'b0;
            len_now   = 0;
        end

        if (step_res.size() != 0)
        begin
            tail = step_res.pop_back();
            tail.last_of_run = 1'b1;
            step_res.push_back(tail);
        end
    endfunction

    function automatic feed_t plain(logic [7:0] c, logic eos);
        feed_t f;
        f = '0;
        f.item.source_byte   = c;
        f.item.end_of_source = eos;
        return f;
    endfunction

    // scripted row whose single event is written out in full
    function automatic feed_t pinned(logic [7:0] c, logic eos, logic [2:0] ev,
                                     logic [3:0] code, logic [6:0] depth);
        feed_t f;
        f = plain(c, eos);
        f.pinned            = 1'b1;
        f.want.event_res    = ev;
        f.want.error_code   = code;
        f.want.nest_depth   = depth;
        f.want.token_length = '0;
        f.want.last_of_run  = 1'b1;
        return f;
    endfunction

    function automatic logic [7:0] blank();
        logic [7:0] c;
        c = 8'($urandom_range(9, 13));
        return $urandom_range(0, 1) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] id_char(bit first);
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_CLOSE ||
               (first && (c == CH_OPEN || c == CH_QUOTE || is_digit_ch(c))))
            c = 8'($urandom_range(8'h21, 8'h7E));
        return c;
    endfunction

    // Append one list to run_text; a rare flaw breaks an atom on purpose.
    task automatic write_list(input int lvl);
        int         n, k, m;
        bit         flaw;
        logic [7:0] c;
        run_text.push_back(CH_OPEN);
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
        begin
            if (k != 0 || $urandom_range(0, 3) == 0)
                run_text.push_back(blank());
            flaw = ($urandom_range(0, 11) == 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    m = $urandom_range(1, 3);
                    repeat (m) run_text.push_back(8'($urandom_range(8'h30, 8'h39)));
                    if ($urandom_range(0, 1))
                    begin
                        run_text.push_back(CH_DOT);
                        repeat ($urandom_range(0, 2))
                            run_text.push_back(8'($urandom_range(8'h30, 8'h39)));
                    end
                    if ($urandom_range(0, 7) == 0)
                        run_text.push_back("e");
                    if (flaw)
                        run_text.push_back($urandom_range(0, 1) ? CH_DOT : "#");
                end
                1:
                begin
                    run_text.push_back(id_char(1'b1));
                    repeat ($urandom_range(0, 4)) run_text.push_back(id_char(1'b0));
                    if (flaw)
                        run_text.push_back(8'($urandom_range(8'h80, 8'hFF)));
                end
                2:
                begin
                    run_text.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            run_text.push_back(CH_ESC);
                            run_text.push_back(8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            c = 8'($urandom_range(0, 255));
                            while (c == CH_QUOTE || c == CH_ESC)
                                c = 8'($urandom_range(0, 255));
                            run_text.push_back(c);
                        end
                    end
                    run_text.push_back(CH_QUOTE);
                    if (flaw)
                        run_text.push_back("x");
                end
                default:
                    if (lvl < 2)
                        write_list(lvl + 1);
                    else
                        run_text.push_back("z");
            endcase
        end
        if ($urandom_range(0, 1))
            run_text.push_back(blank());
        run_text.push_back(CH_CLOSE);
    endtask

    // One source: mostly a well-formed list, sometimes noise, a stray byte or a cut end.
    task automatic queue_run();
        int k, cut;
        run_text.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) run_text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) run_text.push_back(blank());
            write_list(0);
            if ($urandom_range(0, 1))
                run_text.push_back(blank());
            case ($urandom_range(0, 9))
                0: run_text[$urandom_range(0, run_text.size() - 1)] =
                       8'($urandom_range(0, 255));
                1:
                begin
                    cut = $urandom_range(1, run_text.size());
                    while (run_text.size() > cut)
                        void'(run_text.pop_back());
                end
                default: ;
            endcase
        end
        for (k = 0; k < run_text.size(); k++)
            src_queue.push_back(plain(run_text[k], k == run_text.size() - 1));
        bytes_queued += run_text.size();
    endtask

    // Source side: hold the request until taken, then maybe idle.
    always @(negedge clk)
    begin : feed_side
        feed_t nxt;
        if (!src_valid || src_took)
        begin
            if (src_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 35))
            begin
                nxt = src_queue.pop_front();
                src_item  <= nxt.item;
                src_now   <= nxt;
                src_valid <= 1'b1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    // Result side: random stalls plus one long hold-off.
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= !no_idle && ($urandom_range(0, 99) < 35);
    end

    always @(posedge clk)
    begin : watch_side
        sxt_pkg::out_t want;
        if (rst_n)
        begin
            src_took <= src_valid && !src_stall;
            if (src_valid && !src_stall)
            begin
                bytes_taken++;
                tokenize_byte(src_now.item);
                if (src_now.pinned)
                    pending_events.push_back(src_now.want);
                else
                    foreach (step_res[i]) pending_events.push_back(step_res[i]);
            end

            if (res_valid && !res_stall)
            begin
                events_checked++;
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected event ev=%0d err=%0d depth=%0d len=%0d last=%0b",
                             $time, res_item.event_res, res_item.error_code,
                             res_item.nest_depth, res_item.token_length, res_item.last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (want.event_res == sxt_pkg::EV_ERR)
                        errors_seen++;
                    if (want.event_res == sxt_pkg::EV_OK)
                        sources_ok++;
                    if (res_item.event_res    !== want.event_res    ||
                        res_item.error_code   !== want.error_code   ||
                        res_item.nest_depth   !== want.nest_depth   ||
                        res_item.token_length !== want.token_length ||
                        res_item.last_of_run  !== want.last_of_run)
                    begin
                        $display("%0t: expected ev=%0d err=%0d depth=%0d len=%0d last=%0b",
                                 $time, want.event_res, want.error_code, want.nest_depth,
                                 want.token_length, want.last_of_run);
                        $display("%0t:   actual ev=%0d err=%0d depth=%0d len=%0d last=%0b",
                                 $time, res_item.event_res, res_item.error_code,
                                 res_item.nest_depth, res_item.token_length,
                                 res_item.last_of_run);
                        fail_count++;
                    end
                end
            end

            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d events outstanding",
                         $time, STALL_LIMIT, pending_events.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : main_flow
        feed_t script[$];
        int    base;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        script = '{
            plain(CH_SPACE, 1'b0),
            pinned(CH_OPEN, 1'b0, sxt_pkg::EV_OPEN, sxt_pkg::ERR_NONE, 7'd1),
            plain("1", 1'b0),
            plain(CH_DOT, 1'b0),
            plain("5", 1'b0),
            plain(CH_SPACE, 1'b0),
            plain(CH_QUOTE, 1'b0),
            plain(CH_ESC, 1'b0),
            plain(CH_QUOTE, 1'b0),
            plain(CH_QUOTE, 1'b0),
            plain(CH_CLOSE, 1'b0),
            pinned(8'h0A, 1'b1, sxt_pkg::EV_OK, sxt_pkg::ERR_NONE, 7'd0),
            pinned(8'hFF, 1'b0, sxt_pkg::EV_ERR, sxt_pkg::ERR_BAD_TOP, 7'd0),
            plain("x", 1'b1),
            plain(CH_OPEN, 1'b0),
            plain("a", 1'b0),
            plain(CH_SPACE, 1'b0),
            plain("b", 1'b0),
            pinned(8'h00, 1'b1, sxt_pkg::EV_ERR, sxt_pkg::ERR_BAD_ID_CHAR, 7'd1),
            plain(CH_OPEN, 1'b0),
            plain(CH_QUOTE, 1'b0),
            plain(CH_QUOTE, 1'b1),
            plain(CH_OPEN, 1'b1),
            plain(CH_OPEN, 1'b0),
            plain("7", 1'b1)
        };
        foreach (script[i]) src_queue.push_back(script[i]);
        while (src_queue.size() != 0) @(posedge clk);

        // random sources; the receiver backs off hard right at the start
        base    = bytes_queued;
        hold_go = 1'b1;
        while (bytes_queued - base < RANDOM_ITEMS)
        begin
            queue_run();
            while (src_queue.size() > 16) @(posedge clk);
        end
        while (src_queue.size() != 0) @(posedge clk);

        // nest to the limit, then one level too deep; no idling here
        no_idle = 1'b1;
        repeat (sxt_pkg::MAX_DEPTH + 1) src_queue.push_back(plain(CH_OPEN, 1'b0));
        src_queue.push_back(plain("z", 1'b1));
        while (src_queue.size() != 0) @(posedge clk);
        no_idle = 1'b0;

        while (src_queue.size() != 0 || src_valid) @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d source bytes and %0d events: %0d errors, %0d clean sources,",
                 bytes_taken, events_checked, errors_seen, sources_ok);
        $display("nesting up to %0d including the depth limit; %0d mismatches.",
                 deepest, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
